/* hdl/apid_pkg.sv */
// ---------------------------------------------------------------------------
// Angle PID package
// Widths, fixed-point constants, register indexes and shared helpers for
// the angle PID controller.
// ---------------------------------------------------------------------------
package apid_pkg;

  localparam int AngleW   = 16;
  localparam int ErrW     = AngleW + 1;
  localparam int GainW    = 24;
  localparam int IntW     = 32;
  localparam int DriveW   = 12;
  localparam int FracBits = 20;
  localparam int CfgIdxW  = 2;
  localparam int SumW     = 44;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgKp = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKi = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKd = 2'd2;

  // Half and full turn in 1/16 degree.
  localparam logic signed [ErrW-1:0] HalfTurn = 17'sd2880;
  localparam logic signed [ErrW-1:0] FullTurn = 17'sd5760;

  localparam int DriveLimit = 1500;
  // Drive limit with 20 fraction bits.
  localparam logic signed [IntW-1:0] LimitFixed = 32'sd1572864000;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
  } gains_t;

  function automatic logic signed [IntW-1:0] clamp_fixed(
    input logic signed [SumW-1:0] v
  );
    logic signed [SumW-1:0] lim;
    logic signed [IntW-1:0] res;
    lim = SumW'(LimitFixed);
    if (v > lim) begin
      res = LimitFixed;
    end else if (v < -lim) begin
      res = -LimitFixed;
    end else begin
      res = v[IntW-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/apid_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Angle PID gain registers
// Holds kp, ki and kd, written through a plain indexed write port.
// ---------------------------------------------------------------------------
module apid_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apid_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [apid_pkg::GainW-1:0]   cfg_wdata_i,
  output apid_pkg::gains_t             gains_o
);
  import apid_pkg::*;

  gains_t gains_q, gains_d;

  always_comb begin
    gains_d = gains_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKp:   gains_d.kp = cfg_wdata_i;
        CfgKi:   gains_d.ki = cfg_wdata_i;
        CfgKd:   gains_d.kd = cfg_wdata_i;
        default: gains_d = gains_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

/* hdl/apid_error.sv */
// ---------------------------------------------------------------------------
// Angle PID error unit
// Forms target minus measured angle and wraps it once by a full turn.
// ---------------------------------------------------------------------------
module apid_error (
  input  logic signed [apid_pkg::AngleW-1:0] target_i,
  input  logic signed [apid_pkg::AngleW-1:0] measured_i,
  output logic signed [apid_pkg::ErrW-1:0]   err_o
);
  import apid_pkg::*;

  logic signed [ErrW-1:0] diff;

  assign diff = ErrW'(target_i) - ErrW'(measured_i);

  // Only one wrap is applied; angles far outside one turn keep a large error.
  always_comb begin
    if (diff > HalfTurn) begin
      err_o = diff - FullTurn;
    end else if (diff < -HalfTurn) begin
      err_o = diff + FullTurn;
    end else begin
      err_o = diff;
    end
  end

endmodule

/* hdl/apid_datapath.sv */
// ---------------------------------------------------------------------------
// Angle PID datapath
// Integrator and previous-error state, gain products and output clamp.
// ---------------------------------------------------------------------------
module apid_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [apid_pkg::ErrW-1:0]  err_i,
  input  apid_pkg::gains_t                  gains_i,
  output logic signed [apid_pkg::DriveW-1:0] drive_o
);
  import apid_pkg::*;

  localparam int ProdW  = GainW + ErrW;
  localparam int DeltaW = ErrW + 1;
  localparam int DProdW = GainW + DeltaW;

  logic signed [IntW-1:0]   integ_q, integ_d;
  logic signed [ErrW-1:0]   prev_err_q;
  logic signed [GainW-1:0]  kp, ki, kd;
  logic signed [DeltaW-1:0] delta;
  logic signed [ProdW-1:0]  kp_prod, ki_prod;
  logic signed [DProdW-1:0] kd_prod;
  logic signed [SumW-1:0]   acc, sum;
  logic signed [IntW-1:0]   sum_clamped;

  assign kp = gains_i.kp;
  assign ki = gains_i.ki;
  assign kd = gains_i.kd;

  assign delta   = DeltaW'(err_i) - DeltaW'(prev_err_q);
  assign kp_prod = ProdW'(kp) * ProdW'(err_i);
  assign ki_prod = ProdW'(ki) * ProdW'(err_i);
  assign kd_prod = DProdW'(kd) * DProdW'(delta);

  // The integrator saturates before it feeds the output sum.
  assign acc     = SumW'(integ_q) + SumW'(ki_prod);
  assign integ_d = clamp_fixed(acc);

  assign sum         = SumW'(kp_prod) + SumW'(integ_d) + SumW'(kd_prod);
  assign sum_clamped = clamp_fixed(sum);

  // Dropping the fraction bits of a two's complement value rounds down.
  assign drive_o = sum_clamped[FracBits +: DriveW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
    end else if (en_i) begin
      integ_q    <= integ_d;
      prev_err_q <= err_i;
    end
  end

endmodule

/* hdl/angle_pid_controller_core.sv */
// ---------------------------------------------------------------------------
// Angle PID controller core
// A request on the slave stream carries a target and a measured angle in
// 1/16 degree; the master stream returns one saturated drive value for each.
// Gains kp, ki and kd (signed, 20 fraction bits) are set through the write
// port while the block is idle; writes to an unused index are ignored.
// An accepted request is stored in the input register, then crosses the PID
// datapath into the output register once the output register is free.
// Throughput is one request per cycle while the receiver takes each output;
// the datapath updates its integrator once for each request.
// Reset clears the gains, the integrator, the previous error and both
// valid flags. When the receiver stalls, the output holds its value, the
// input register keeps one more request, and then tready drops until the
// output is taken.
// ---------------------------------------------------------------------------
module angle_pid_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apid_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [apid_pkg::GainW-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] target_angle, [31:16] measured_angle
  input  logic [31:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [11:0] drive, [15:12] zero
  output logic [15:0]                  m_axis_tdata
);
  import apid_pkg::*;

  gains_t gains;

  logic                     in_valid_q, in_valid_d;
  logic signed [AngleW-1:0] target_q, measured_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [DriveW-1:0] drive_q;
  logic signed [DriveW-1:0] drive_d;
  logic signed [ErrW-1:0]   err;
  logic                     out_free;
  logic                     advance;
  logic                     in_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      target_q   <= s_axis_tdata[AngleW-1:0];
      measured_q <= s_axis_tdata[2*AngleW-1:AngleW];
    end
    if (advance) begin
      drive_q <= drive_d;
    end
  end

  apid_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .gains_o     (gains)
  );

  apid_error u_error (
    .target_i   (target_q),
    .measured_i (measured_q),
    .err_o      (err)
  );

  apid_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .err_i   (err),
    .gains_i (gains),
    .drive_o (drive_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - DriveW){1'b0}}, drive_q};

endmodule

/* hdl/apid_checker.sv */
// ---------------------------------------------------------------------------
// Angle PID port checker
// Checks drive range, output padding, stall behavior and input readiness.
// ---------------------------------------------------------------------------
module apid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import apid_pkg::*;

  logic signed [DriveW-1:0] drive;
  logic signed [DriveW-1:0] lim;

  assign drive = m_axis_tdata[DriveW-1:0];
  assign lim   = DriveW'(DriveLimit);

  // The saturated drive never leaves its limits.
  a_drive_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (drive <= lim) && (drive >= -lim))
    else $error("drive value outside the limits");

  a_pad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:DriveW] == '0))
    else $error("padding bits of the output are not zero");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed or dropped");

  // A ready receiver lets a new request in every cycle.
  a_in_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the output side is ready");

  a_reset_idle : assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind angle_pid_controller_core apid_checker u_checker (.*);
